/* hw/rtl/swk_pkg.sv */
// Shared types, constants and tables for the swerve wheel kinematics block.
// No dependencies; imported by every other file of the block but swk_mul.
package swk_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int DIV_STEPS    = 32;
   localparam int SQRT_STEPS   = 18;

   localparam logic [4:0] DIV_LAST    = 5'(DIV_STEPS - 1);
   localparam logic [4:0] SQRT_LAST   = 5'(SQRT_STEPS - 1);
   localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_STEPS - 1);

   localparam int CSR_AW = 5;

   localparam logic [2:0] REG_DEADZONE   = 3'd0;
   localparam logic [2:0] REG_MAX_PLANAR = 3'd1;
   localparam logic [2:0] REG_HALF_WBASE = 3'd2;
   localparam logic [2:0] REG_HALF_TRACK = 3'd3;
   localparam logic [2:0] REG_MOTOR_FS   = 3'd4;
   localparam logic [2:0] REG_HOLD_THR   = 3'd5;

   localparam logic [14:0] RST_DEADZONE   = 15'd3277;
   localparam logic [14:0] RST_MAX_PLANAR = 15'd16384;
   localparam logic [14:0] RST_HALF_WBASE = 15'd8192;
   localparam logic [14:0] RST_HALF_TRACK = 15'd8192;
   localparam logic [15:0] RST_MOTOR_FS   = 16'd1000;
   localparam logic [14:0] RST_HOLD_THR   = 15'd16;

   // arctan(2^-i) in 32-bit binary angle
   localparam logic [31:0] ATAN_TAB [24] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   typedef enum logic [1:0] {
      OP_DIV,
      OP_SQRT,
      OP_CORDIC
   } iter_op_type;

   typedef struct packed {
      logic        start;
      iter_op_type op;
   } iter_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } iter_sts_type;

   typedef struct packed {
      logic [14:0] deadzone;
      logic [14:0] max_planar_speed;
      logic [14:0] wbase_gain;
      logic [14:0] half_track;
      logic [15:0] motor_full_scale;
      logic [14:0] hold_threshold;
   } cfg_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DZ, S_DZ_W, S_MX, S_MY, S_MS, S_MAG_W,
      S_LIM_M, S_LIM_D, S_LIM_W, S_ROT, S_ROT2, S_ROT3, S_WV,
      S_SP_X, S_SP_Y, S_SP_S, S_SP_W, S_SCALE, S_SC_W,
      S_WH, S_WH_S, S_CD_W, S_FLIP, S_MOT, S_OUT
   } seq_state_type;

endpackage

/* hw/rtl/swk_csr.sv */
// APB-style configuration register file for the swerve wheel kinematics block.
// Depends on swk_pkg.
module swk_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [swk_pkg::CSR_AW-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output swk_pkg::cfg_type            cfg
);
   import swk_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] idx;
   logic       wr;

   assign idx    = paddr[4:2];
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_DEADZONE:   cfg_in.deadzone         = pwdata[14:0];
            REG_MAX_PLANAR: cfg_in.max_planar_speed = pwdata[14:0];
            REG_HALF_WBASE: cfg_in.wbase_gain       = pwdata[14:0];
            REG_HALF_TRACK: cfg_in.half_track       = pwdata[14:0];
            REG_MOTOR_FS:   cfg_in.motor_full_scale = pwdata[15:0];
            REG_HOLD_THR:   cfg_in.hold_threshold   = pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_DEADZONE:   prdata = {17'd0, cfg_ff.deadzone};
         REG_MAX_PLANAR: prdata = {17'd0, cfg_ff.max_planar_speed};
         REG_HALF_WBASE: prdata = {17'd0, cfg_ff.wbase_gain};
         REG_HALF_TRACK: prdata = {17'd0, cfg_ff.half_track};
         REG_MOTOR_FS:   prdata = {16'd0, cfg_ff.motor_full_scale};
         REG_HOLD_THR:   prdata = {17'd0, cfg_ff.hold_threshold};
         default:        prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadzone         <= RST_DEADZONE;
         cfg_ff.max_planar_speed <= RST_MAX_PLANAR;
         cfg_ff.wbase_gain       <= RST_HALF_WBASE;
         cfg_ff.half_track       <= RST_HALF_TRACK;
         cfg_ff.motor_full_scale <= RST_MOTOR_FS;
         cfg_ff.hold_threshold   <= RST_HOLD_THR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hw/rtl/swk_mul.sv */
// Shared 18x18 unsigned multiplier with registered product, loaded on enable.
// Depends on nothing.
module swk_mul (
   input  logic        clock,
   input  logic        en,
   input  logic [17:0] a,
   input  logic [17:0] b,
   output logic [35:0] prod
);

   logic [35:0] prod_ff;

   assign prod = prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= 36'(a) * 36'(b);
      end
   end

endmodule

/* hw/rtl/swk_iter.sv */
// Shared iterative unit: restoring divide, restoring square root and CORDIC
// vectoring, one bit or one rotation per cycle. Depends on swk_pkg.
module swk_iter (
   input  logic                  clock,
   input  logic                  reset,
   input  swk_pkg::iter_cmd_type cmd,
   input  logic [35:0]           num,
   input  logic [17:0]           den,
   input  logic signed [17:0]    cx,
   input  logic signed [17:0]    cy,
   output logic [31:0]           res,
   output swk_pkg::iter_sts_type sts
);
   import swk_pkg::*;

   function automatic logic signed [27:0] trunc_shift(input logic signed [27:0] v,
                                                      input logic [4:0] sh);
      logic signed [27:0] bias;
      bias = v[27] ? ((28'sd1 <<< sh) - 28'sd1) : 28'sd0;
      return (v + bias) >>> sh;
   endfunction

   logic               busy_ff, busy_in, done_ff, done_in;
   iter_op_type        op_ff, op_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [31:0]        quo_ff, quo_in;
   logic [17:0]        rem_ff, rem_in, dvr_ff, dvr_in;
   logic [35:0]        rad_ff, rad_in;
   logic [19:0]        srem_ff, srem_in;
   logic [17:0]        root_ff, root_in;
   logic signed [27:0] x_ff, x_in, y_ff, y_in;
   logic [31:0]        z_ff, z_in;

   logic [18:0]        dsh;
   logic [21:0]        ssh, trial;
   logic signed [27:0] x0, y0, xs, ys;
   logic [4:0]         last;
   logic [31:0]        zr;

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign zr       = z_ff + 32'h0000_8000;

   always_comb begin
      unique case (op_ff)
         OP_DIV:    res = quo_ff;
         OP_SQRT:   res = {14'd0, root_ff};
         OP_CORDIC: res = {16'd0, zr[31:16]};
         default:   res = 32'd0;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvr_in  = dvr_ff;
      rad_in  = rad_ff;
      srem_in = srem_ff;
      root_in = root_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      x0      = {{2{cx[17]}}, cx, 8'd0};
      y0      = {{2{cy[17]}}, cy, 8'd0};
      dsh     = {rem_ff, quo_ff[31]};
      ssh     = {srem_ff, rad_ff[35:34]};
      trial   = {2'b00, root_ff, 2'b01};
      xs      = trunc_shift(x_ff, cnt_ff);
      ys      = trunc_shift(y_ff, cnt_ff);
      unique case (op_ff)
         OP_DIV:    last = DIV_LAST;
         OP_SQRT:   last = SQRT_LAST;
         OP_CORDIC: last = CORDIC_LAST;
         default:   last = 5'd0;
      endcase

      if (cmd.start) begin
         op_in   = cmd.op;
         busy_in = 1'b1;
         cnt_in  = 5'd0;
         unique case (cmd.op)
            OP_DIV: begin
               quo_in = num[31:0];
               rem_in = 18'd0;
               dvr_in = den;
            end
            OP_SQRT: begin
               rad_in  = num;
               srem_in = 20'd0;
               root_in = 18'd0;
            end
            OP_CORDIC: begin
               if (x0 < 0) begin
                  if (y0 >= 0) begin
                     x_in = y0;
                     y_in = -x0;
                     z_in = 32'h4000_0000;
                  end else begin
                     x_in = -y0;
                     y_in = x0;
                     z_in = 32'hC000_0000;
                  end
               end else begin
                  x_in = x0;
                  y_in = y0;
                  z_in = 32'd0;
               end
            end
            default: busy_in = 1'b0;
         endcase
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         unique case (op_ff)
            OP_DIV: begin
               if (dsh >= {1'b0, dvr_ff}) begin
                  rem_in = 18'(dsh - {1'b0, dvr_ff});
                  quo_in = {quo_ff[30:0], 1'b1};
               end else begin
                  rem_in = dsh[17:0];
                  quo_in = {quo_ff[30:0], 1'b0};
               end
            end
            OP_SQRT: begin
               rad_in = {rad_ff[33:0], 2'b00};
               if (ssh >= trial) begin
                  srem_in = 20'(ssh - trial);
                  root_in = {root_ff[16:0], 1'b1};
               end else begin
                  srem_in = ssh[19:0];
                  root_in = {root_ff[16:0], 1'b0};
               end
            end
            OP_CORDIC: begin
               if (y_ff > 0) begin
                  x_in = x_ff + ys;
                  y_in = y_ff - xs;
                  z_in = z_ff + ATAN_TAB[cnt_ff];
               end else begin
                  x_in = x_ff - ys;
                  y_in = y_ff + xs;
                  z_in = z_ff - ATAN_TAB[cnt_ff];
               end
            end
            default: busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= OP_DIV;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvr_ff  <= dvr_in;
      rad_ff  <= rad_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

endmodule

/* hw/rtl/swerve_wheel_kinematics_top.sv */
// Swerve wheel kinematics: one joystick command in, four wheel results out, one
// command at a time. A command is taken only while the block is idle and is
// worked through on the shared iterative unit (divides, square roots and
// arctangents) and the shared multiplier; a deadzone divide is skipped for
// an axis inside the deadzone, the planar limit and normalisation divides
// only run when they apply, and the arctangent is skipped for a held or
// zero-length wheel. The last wheel result may wait in the output register
// while the next command is taken. Depends on swk_pkg, swk_csr, swk_mul and
// swk_iter.
module swerve_wheel_kinematics_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [15:0]         req_move_x,
   input  logic signed [15:0]         req_move_y,
   input  logic signed [15:0]         req_rotate_z,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_wheel_index,
   output logic signed [15:0]         rsp_steer_angle,
   output logic signed [15:0]         rsp_signed_speed,
   output logic                       rsp_reverse,
   output logic [15:0]                rsp_motor_speed,
   output logic [15:0]                rsp_peak_speed,
   output logic [14:0]                rsp_scale_factor,
   output logic                       rsp_last_wheel,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [swk_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   import swk_pkg::*;

   function automatic logic [17:0] mag18(input logic signed [17:0] v);
      return v[17] ? 18'(-v) : 18'(v);
   endfunction

   cfg_type            cfg;
   iter_cmd_type       cmd;
   iter_sts_type       sts;
   logic [35:0]        num;
   logic [17:0]        den;
   logic signed [17:0] cx, cy;
   logic [31:0]        res;
   logic               mul_en;
   logic [17:0]        mul_a, mul_b;
   logic [35:0]        prod;

   seq_state_type      state_ff, state_in;
   logic [1:0]         idx_ff, idx_in;
   logic signed [17:0] v_ff [3];
   logic signed [17:0] v_in [3];
   logic [17:0]        mag_ff, mag_in;
   logic [35:0]        acc_ff, acc_in;
   logic signed [17:0] tw_ff, tw_in, tl_ff, tl_in;
   logic signed [17:0] wx_ff [4];
   logic signed [17:0] wx_in [4];
   logic signed [17:0] wy_ff [4];
   logic signed [17:0] wy_in [4];
   logic [17:0]        spd_ff [4];
   logic [17:0]        spd_in [4];
   logic [17:0]        peak_ff, peak_in;
   logic [14:0]        scale_ff, scale_in;
   logic signed [15:0] s14_ff, s14_in;
   logic [15:0]        ang_ff, ang_in;
   logic [15:0]        prev_ff [4];
   logic [15:0]        prev_in [4];

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_idx_ff, rsp_idx_in;
   logic [15:0]        rsp_ang_ff, rsp_ang_in;
   logic signed [15:0] rsp_spd_ff, rsp_spd_in;
   logic               rsp_rev_ff, rsp_rev_in;
   logic [15:0]        rsp_mot_ff, rsp_mot_in;
   logic [15:0]        rsp_pk_ff, rsp_pk_in;
   logic [14:0]        rsp_sc_ff, rsp_sc_in;
   logic               rsp_last_ff, rsp_last_in;

   logic signed [17:0] v_cur;
   logic [17:0]        a_cur, d18, dz_diff, rq;
   logic [15:0]        lim;
   logic [17:0]        tq;
   logic [14:0]        s15;
   logic signed [15:0] diff;
   logic [16:0]        pk17;
   logic               out_load;

   swk_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   swk_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   swk_iter u_iter (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .num   (num),
      .den   (den),
      .cx    (cx),
      .cy    (cy),
      .res   (res),
      .sts   (sts)
   );

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_wheel_index  = rsp_idx_ff;
   assign rsp_steer_angle  = rsp_ang_ff;
   assign rsp_signed_speed = rsp_spd_ff;
   assign rsp_reverse      = rsp_rev_ff;
   assign rsp_motor_speed  = rsp_mot_ff;
   assign rsp_peak_speed   = rsp_pk_ff;
   assign rsp_scale_factor = rsp_sc_ff;
   assign rsp_last_wheel   = rsp_last_ff;

   assign v_cur   = v_ff[idx_ff];
   assign a_cur   = mag18(v_cur);
   assign d18     = {3'd0, cfg.deadzone};
   assign dz_diff = a_cur - d18;
   assign rq      = (res > 32'd32768) ? 18'd32768 : res[17:0];
   assign lim     = {cfg.max_planar_speed, 1'b0};
   assign tq      = prod[31:14];
   assign s15     = prod[29:15];
   assign diff    = signed'(ang_ff - prev_ff[idx_ff]);
   assign pk17    = peak_ff[17:1];
   assign out_load = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      v_in     = v_ff;
      mag_in   = mag_ff;
      acc_in   = acc_ff;
      tw_in    = tw_ff;
      tl_in    = tl_ff;
      wx_in    = wx_ff;
      wy_in    = wy_ff;
      spd_in   = spd_ff;
      peak_in  = peak_ff;
      scale_in = scale_ff;
      s14_in   = s14_ff;
      ang_in   = ang_ff;
      prev_in  = prev_ff;
      mul_en   = 1'b0;
      mul_a    = 18'd0;
      mul_b    = 18'd0;
      cmd.start = 1'b0;
      cmd.op   = OP_DIV;
      num      = 36'd0;
      den      = 18'd0;
      cx       = wx_ff[idx_ff];
      cy       = wy_ff[idx_ff];

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_idx_in   = rsp_idx_ff;
      rsp_ang_in   = rsp_ang_ff;
      rsp_spd_in   = rsp_spd_ff;
      rsp_rev_in   = rsp_rev_ff;
      rsp_mot_in   = rsp_mot_ff;
      rsp_pk_in    = rsp_pk_ff;
      rsp_sc_in    = rsp_sc_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               v_in[0]  = 18'(req_move_x);
               v_in[1]  = 18'(req_move_y);
               v_in[2]  = 18'(req_rotate_z);
               idx_in   = 2'd0;
               state_in = S_DZ;
            end
         end
         S_DZ: begin
            if (a_cur < d18) begin
               v_in[idx_ff] = 18'sd0;
               idx_in       = (idx_ff == 2'd2) ? 2'd0 : idx_ff + 2'd1;
               state_in     = (idx_ff == 2'd2) ? S_MX : S_DZ;
            end else begin
               cmd.start = 1'b1;
               cmd.op    = OP_DIV;
               num       = {4'd0, dz_diff[16:0], 15'd0};
               den       = 18'd32768 - d18;
               state_in  = S_DZ_W;
            end
         end
         S_DZ_W: begin
            if (sts.done) begin
               v_in[idx_ff] = v_cur[17] ? -signed'(rq) : signed'(rq);
               idx_in       = (idx_ff == 2'd2) ? 2'd0 : idx_ff + 2'd1;
               state_in     = (idx_ff == 2'd2) ? S_MX : S_DZ;
            end
         end
         S_MX: begin
            mul_en   = 1'b1;
            mul_a    = mag18(v_ff[0]);
            mul_b    = mag18(v_ff[0]);
            state_in = S_MY;
         end
         S_MY: begin
            acc_in   = prod;
            mul_en   = 1'b1;
            mul_a    = mag18(v_ff[1]);
            mul_b    = mag18(v_ff[1]);
            state_in = S_MS;
         end
         S_MS: begin
            cmd.start = 1'b1;
            cmd.op    = OP_SQRT;
            num       = acc_ff + prod;
            state_in  = S_MAG_W;
         end
         S_MAG_W: begin
            if (sts.done) begin
               mag_in = res[17:0];
               idx_in = 2'd0;
               state_in = (res[17:0] > {2'd0, lim}) ? S_LIM_M : S_ROT;
            end
         end
         S_LIM_M: begin
            mul_en   = 1'b1;
            mul_a    = a_cur;
            mul_b    = {2'd0, lim};
            state_in = S_LIM_D;
         end
         S_LIM_D: begin
            cmd.start = 1'b1;
            cmd.op    = OP_DIV;
            num       = prod;
            den       = mag_ff;
            state_in  = S_LIM_W;
         end
         S_LIM_W: begin
            if (sts.done) begin
               v_in[idx_ff] = v_cur[17] ? -signed'(res[17:0]) : signed'(res[17:0]);
               idx_in       = 2'd1;
               state_in     = (idx_ff == 2'd1) ? S_ROT : S_LIM_M;
            end
         end
         S_ROT: begin
            mul_en   = 1'b1;
            mul_a    = mag18(v_ff[2]);
            mul_b    = {3'd0, cfg.half_track};
            state_in = S_ROT2;
         end
         S_ROT2: begin
            tw_in    = v_ff[2][17] ? -signed'(tq) : signed'(tq);
            mul_en   = 1'b1;
            mul_a    = mag18(v_ff[2]);
            mul_b    = {3'd0, cfg.wbase_gain};
            state_in = S_ROT3;
         end
         S_ROT3: begin
            tl_in    = v_ff[2][17] ? -signed'(tq) : signed'(tq);
            state_in = S_WV;
         end
         S_WV: begin
            wx_in[0] = v_ff[0] - tw_ff;
            wx_in[1] = v_ff[0] + tw_ff;
            wx_in[2] = v_ff[0] - tw_ff;
            wx_in[3] = v_ff[0] + tw_ff;
            wy_in[0] = v_ff[1] + tl_ff;
            wy_in[1] = v_ff[1] + tl_ff;
            wy_in[2] = v_ff[1] - tl_ff;
            wy_in[3] = v_ff[1] - tl_ff;
            idx_in   = 2'd0;
            peak_in  = 18'd0;
            state_in = S_SP_X;
         end
         S_SP_X: begin
            mul_en   = 1'b1;
            mul_a    = mag18(wx_ff[idx_ff]);
            mul_b    = mag18(wx_ff[idx_ff]);
            state_in = S_SP_Y;
         end
         S_SP_Y: begin
            acc_in   = prod;
            mul_en   = 1'b1;
            mul_a    = mag18(wy_ff[idx_ff]);
            mul_b    = mag18(wy_ff[idx_ff]);
            state_in = S_SP_S;
         end
         S_SP_S: begin
            cmd.start = 1'b1;
            cmd.op    = OP_SQRT;
            num       = acc_ff + prod;
            state_in  = S_SP_W;
         end
         S_SP_W: begin
            if (sts.done) begin
               spd_in[idx_ff] = res[17:0];
               if (res[17:0] > peak_ff) begin
                  peak_in = res[17:0];
               end
               idx_in   = idx_ff + 2'd1;
               state_in = (idx_ff == 2'd3) ? S_SCALE : S_SP_X;
            end
         end
         S_SCALE: begin
            idx_in = 2'd0;
            if (peak_ff > 18'd32768) begin
               cmd.start = 1'b1;
               cmd.op    = OP_DIV;
               num       = 36'd1 << 29;
               den       = peak_ff;
               state_in  = S_SC_W;
            end else begin
               scale_in = 15'd16384;
               state_in = S_WH;
            end
         end
         S_SC_W: begin
            if (sts.done) begin
               scale_in = res[14:0];
               state_in = S_WH;
            end
         end
         S_WH: begin
            mul_en   = 1'b1;
            mul_a    = spd_ff[idx_ff];
            mul_b    = {3'd0, scale_ff};
            state_in = S_WH_S;
         end
         S_WH_S: begin
            s14_in = {1'b0, s15};
            if (s15 < cfg.hold_threshold) begin
               ang_in   = prev_ff[idx_ff];
               state_in = S_FLIP;
            end else if (wx_ff[idx_ff] == 18'sd0 && wy_ff[idx_ff] == 18'sd0) begin
               ang_in   = 16'd0;
               state_in = S_FLIP;
            end else begin
               cmd.start = 1'b1;
               cmd.op    = OP_CORDIC;
               state_in  = S_CD_W;
            end
         end
         S_CD_W: begin
            if (sts.done) begin
               ang_in   = res[15:0];
               state_in = S_FLIP;
            end
         end
         S_FLIP: begin
            if (diff > 16'sd16384 || diff < -16'sd16384) begin
               ang_in = ang_ff + 16'h8000;
               s14_in = -s14_ff;
            end
            state_in = S_MOT;
         end
         S_MOT: begin
            mul_en   = 1'b1;
            mul_a    = s14_ff[15] ? 18'(-s14_ff) : 18'(s14_ff);
            mul_b    = {2'd0, cfg.motor_full_scale};
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_load) begin
               rsp_valid_in    = 1'b1;
               rsp_idx_in      = idx_ff;
               rsp_ang_in      = ang_ff;
               rsp_spd_in      = s14_ff;
               rsp_rev_in      = s14_ff[15];
               rsp_mot_in      = (|prod[35:30]) ? 16'hFFFF : prod[29:14];
               rsp_pk_in       = pk17[16] ? 16'hFFFF : pk17[15:0];
               rsp_sc_in       = scale_ff;
               rsp_last_in     = (idx_ff == 2'd3);
               prev_in[idx_ff] = ang_ff;
               idx_in          = idx_ff + 2'd1;
               state_in        = (idx_ff == 2'd3) ? S_IDLE : S_WH;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 4; k++) begin
            prev_ff[k] <= 16'd0;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff        <= v_in;
      mag_ff      <= mag_in;
      acc_ff      <= acc_in;
      tw_ff       <= tw_in;
      tl_ff       <= tl_in;
      wx_ff       <= wx_in;
      wy_ff       <= wy_in;
      spd_ff      <= spd_in;
      peak_ff     <= peak_in;
      scale_ff    <= scale_in;
      s14_ff      <= s14_in;
      ang_ff      <= ang_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_ang_ff  <= rsp_ang_in;
      rsp_spd_ff  <= rsp_spd_in;
      rsp_rev_ff  <= rsp_rev_in;
      rsp_mot_ff  <= rsp_mot_in;
      rsp_pk_ff   <= rsp_pk_in;
      rsp_sc_ff   <= rsp_sc_in;
      rsp_last_ff <= rsp_last_in;
   end

`ifndef SYNTH
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      sts.done |-> (state_ff == S_DZ_W || state_ff == S_MAG_W || state_ff == S_LIM_W ||
                    state_ff == S_SP_W || state_ff == S_SC_W || state_ff == S_CD_W))
      else $error("iterative unit finished outside a wait state");

   a_idle_unit_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !sts.busy)
      else $error("iterative unit busy while idle");

   a_scale_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WH) |-> (scale_ff <= 15'd16384))
      else $error("normalisation factor above one");

   a_last_wheel: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_load && idx_ff == 2'd3) |=>
         (rsp_valid && rsp_last_wheel && rsp_wheel_index == 2'd3 && state_ff == S_IDLE))
      else $error("last wheel transaction not flagged");
`endif

endmodule

/* tb/swerve_wheel_kinematics_top_tb.sv */
// Testbench for swerve_wheel_kinematics_top: directed table plus random commands,
// checked against an in-bench fixed-point predictor of the wheel kinematics.
// Depends on swk_pkg and the block's RTL only.
module swerve_wheel_kinematics_top_tb;
   import swk_pkg::*;

   typedef struct {
      logic [1:0]  idx;
      logic [15:0] ang;
      logic [15:0] spd;
      logic        rev;
      logic [15:0] mot;
      logic [15:0] peak;
      logic [14:0] scale;
      logic        last;
   } wheel_res_type;

   typedef struct {
      logic [15:0] x, y, w;
      bit          known;
      logic [15:0] ang0, spd0;
   } cmd_row_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [15:0] req_move_x = 0, req_move_y = 0, req_rotate_z = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [1:0] rsp_wheel_index;
   logic signed [15:0] rsp_steer_angle, rsp_signed_speed;
   logic rsp_reverse, rsp_last_wheel;
   logic [15:0] rsp_motor_speed, rsp_peak_speed;
   logic [14:0] rsp_scale_factor;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_AW-1:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   swerve_wheel_kinematics_top DUT (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // predictor state and configuration
   longint dz, mps, hwb, htr, mfs, hthr;
   logic [15:0] held_angle [4];
   wheel_res_type wheel_q[$];
   int errors = 0;
   bit calm = 0;

   function automatic longint sx16(longint v);
      longint t;
      t = v & 16'hFFFF;
      return (t >= 32768) ? t - 65536 : t;
   endfunction

   function automatic longint isqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint shape_axis(longint v);
      longint a, r;
      a = v < 0 ? -v : v;
      if (a < dz) return 0;
      r = ((a - dz) * 32768) / (32768 - dz);
      if (r > 32768) r = 32768;
      return v < 0 ? -r : r;
   endfunction

   function automatic logic [15:0] vector_angle(longint y, longint x);
      logic [31:0] z;
      longint t, xs, ys;
      z = 32'd0;
      if (x == 0 && y == 0) return 16'd0;
      x *= 256;
      y *= 256;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = 32'h40000000;
         end else begin
            t = x; x = -y; y = t; z = 32'hC0000000;
         end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = x / (longint'(1) << i);
         ys = y / (longint'(1) << i);
         if (y > 0) begin
            x += ys; y -= xs; z += ATAN_TAB[i];
         end else begin
            x -= ys; y += xs; z -= ATAN_TAB[i];
         end
      end
      z = z + 32'h8000;
      return z[31:16];
   endfunction

   task automatic predict_wheels(logic [15:0] ix, logic [15:0] iy, logic [15:0] iw);
      longint vx, vy, vw, lim, mag, tw, tl, s14, diff, pk14, scale, peak;
      longint wx [4], wy [4], sp [4];
      longint unsigned mot;
      logic [15:0] ang, prv;
      wheel_res_type r;
      vx = shape_axis(sx16(ix));
      vy = shape_axis(sx16(iy));
      vw = shape_axis(sx16(iw));
      lim = mps * 2;
      mag = isqrt(vx * vx + vy * vy);
      if (mag > lim) begin
         vx = vx * lim / mag;
         vy = vy * lim / mag;
      end
      tw = vw * htr / 16384;
      tl = vw * hwb / 16384;
      wx[0] = vx - tw; wy[0] = vy + tl;
      wx[1] = vx + tw; wy[1] = vy + tl;
      wx[2] = vx - tw; wy[2] = vy - tl;
      wx[3] = vx + tw; wy[3] = vy - tl;
      peak = 0;
      scale = 16384;
      for (int k = 0; k < 4; k++) begin
         sp[k] = isqrt(wx[k] * wx[k] + wy[k] * wy[k]);
         if (sp[k] > peak) peak = sp[k];
      end
      if (peak > 32768) scale = (longint'(1) << 29) / peak;
      pk14 = peak >> 1;
      if (pk14 > 65535) pk14 = 65535;
      for (int k = 0; k < 4; k++) begin
         s14 = (sp[k] * scale) >>> 15;
         prv = held_angle[k];
         if (s14 < hthr) ang = prv;
         else ang = vector_angle(wy[k], wx[k]);
         diff = sx16(longint'(ang - prv));
         if (diff > 16384 || diff < -16384) begin
            ang = ang + 16'h8000;
            s14 = -s14;
         end
         held_angle[k] = ang;
         mot = ((s14 < 0 ? -s14 : s14) * mfs) >> 14;
         if (mot > 65535) mot = 65535;
         r.idx = k[1:0];
         r.ang = ang;
         r.spd = s14[15:0];
         r.rev = s14 < 0;
         r.mot = mot[15:0];
         r.peak = pk14[15:0];
         r.scale = scale[14:0];
         r.last = (k == 3);
         wheel_q.push_back(r);
      end
   endtask

   task automatic csr_write(logic [2:0] regno, logic [31:0] val);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_paddr <= CSR_AW'(regno) << 2;
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      case (regno)
         REG_DEADZONE:   dz = val & 16'h7FFF;
         REG_MAX_PLANAR: mps = val & 16'h7FFF;
         REG_HALF_WBASE: hwb = val & 16'h7FFF;
         REG_HALF_TRACK: htr = val & 16'h7FFF;
         REG_MOTOR_FS:   mfs = val & 16'hFFFF;
         REG_HOLD_THR:   hthr = val & 16'h7FFF;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_cmd(logic [15:0] x, logic [15:0] y, logic [15:0] w);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_move_x <= x;
      req_move_y <= y;
      req_rotate_z <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_wheels(x, y, w);
      req_valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain;
      while (wheel_q.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);
   endtask

   // result-side stall bursts
   initial begin
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_stall <= 0;
      end
   end

   // checker
   always @(posedge clock) begin
      wheel_res_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (wheel_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected transaction idx %0d", rsp_wheel_index);
         end else begin
            e = wheel_q.pop_front();
            if (e.idx !== rsp_wheel_index || e.ang !== rsp_steer_angle ||
                e.spd !== rsp_signed_speed || e.rev !== rsp_reverse ||
                e.mot !== rsp_motor_speed || e.peak !== rsp_peak_speed ||
                e.scale !== rsp_scale_factor || e.last !== rsp_last_wheel) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch exp %0d %h %h %b %h %h %h %b got %0d %h %h %b %h %h %h %b",
                     e.idx, e.ang, e.spd, e.rev, e.mot, e.peak, e.scale, e.last,
                     rsp_wheel_index, rsp_steer_angle, rsp_signed_speed, rsp_reverse,
                     rsp_motor_speed, rsp_peak_speed, rsp_scale_factor, rsp_last_wheel);
            end
         end
      end
   end

   cmd_row_type rows [16] = '{
      '{16'h0000, 16'h0000, 16'h0000, 1, 16'h0000, 16'h0000},
      '{16'h7FFF, 16'h0000, 16'h0000, 0, 0, 0},
      '{16'h8000, 16'h0000, 16'h0000, 0, 0, 0},
      '{16'h0000, 16'h7FFF, 16'h0000, 0, 0, 0},
      '{16'h0000, 16'h8000, 16'h0000, 0, 0, 0},
      '{16'h0000, 16'h0000, 16'h7FFF, 0, 0, 0},
      '{16'h0000, 16'h0000, 16'h8000, 0, 0, 0},
      '{16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 0},
      '{16'h8000, 16'h8000, 16'h8000, 0, 0, 0},
      '{16'h0CCC, 16'hF334, 16'h0000, 0, 0, 0},
      '{16'h0CCD, 16'h0000, 16'h0000, 0, 0, 0},
      '{16'h8000, 16'h7FFF, 16'h0000, 0, 0, 0},
      '{16'h4000, 16'h0000, 16'h0000, 0, 0, 0},
      '{16'hC000, 16'h0000, 16'h0000, 0, 0, 0},
      '{16'h0000, 16'h0000, 16'h0000, 0, 0, 0},
      '{16'h2000, 16'h2000, 16'hE000, 0, 0, 0}
   };

   task automatic random_phase(int n);
      logic [15:0] x, y, w;
      for (int i = 0; i < n; i++) begin
         x = 16'($urandom);
         y = 16'($urandom);
         w = 16'($urandom);
         if ($urandom_range(0, 4) == 0) w = 0;
         if ($urandom_range(0, 6) == 0) begin
            x = 0; y = 0;
         end
         send_cmd(x, y, w);
      end
   endtask

   initial begin
      int first_n;
      dz = RST_DEADZONE; mps = RST_MAX_PLANAR; hwb = RST_HALF_WBASE;
      htr = RST_HALF_TRACK; mfs = RST_MOTOR_FS; hthr = RST_HOLD_THR;
      foreach (held_angle[k]) held_angle[k] = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (rows[i]) begin
         send_cmd(rows[i].x, rows[i].y, rows[i].w);
         first_n = wheel_q.size() - 4;
         if (rows[i].known &&
             (wheel_q[first_n].ang !== rows[i].ang0 ||
              wheel_q[first_n].spd !== rows[i].spd0)) begin
            errors++;
            if (errors <= 10) $display("predictor disagrees with table row %0d", i);
         end
      end
      random_phase(40);
      drain();
      // extremes of configuration
      csr_write(REG_DEADZONE, 0);
      csr_write(REG_MAX_PLANAR, 32767);
      csr_write(REG_HALF_WBASE, 32767);
      csr_write(REG_HALF_TRACK, 32767);
      csr_write(REG_MOTOR_FS, 65535);
      csr_write(REG_HOLD_THR, 0);
      random_phase(40);
      drain();
      csr_write(REG_DEADZONE, 32767);
      csr_write(REG_MAX_PLANAR, 0);
      csr_write(REG_HALF_WBASE, 0);
      csr_write(REG_HALF_TRACK, 0);
      csr_write(REG_MOTOR_FS, 0);
      csr_write(REG_HOLD_THR, 16384);
      random_phase(20);
      drain();
      csr_write(REG_DEADZONE, $urandom_range(0, 8000));
      csr_write(REG_MAX_PLANAR, $urandom_range(0, 32767));
      csr_write(REG_HALF_WBASE, $urandom_range(0, 32767));
      csr_write(REG_HALF_TRACK, $urandom_range(0, 32767));
      csr_write(REG_MOTOR_FS, $urandom_range(0, 65535));
      csr_write(REG_HOLD_THR, $urandom_range(0, 2000));
      random_phase(54);
      calm = 1;
      random_phase(40);
      drain();
      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #(12 * 800000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
